[rtl/rsrc2d_pkg.sv]
package rsrc2d_pkg;

	localparam int COORD_W   = 24;
	localparam int FRAC      = 14;
	localparam int TRIG_W    = 16;
	localparam int RADIUS_W  = 23;
	localparam int MARK_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = COORD_W;

	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int L_W    = SUM_W - FRAC;
	localparam int ABS_W  = L_W - 1;
	localparam int SQ_W   = 2 * ABS_W;
	localparam int ROOT_W = ABS_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int RSQ_W  = 2 * RADIUS_W;
	localparam int Q_W    = FRAC + 1;
	localparam int DREM_W = ROOT_W + 1;

	localparam int SQ_STEPS_PER_STAGE  = 3;
	localparam int SQ_STAGES           = (ROOT_W + SQ_STEPS_PER_STAGE - 1) / SQ_STEPS_PER_STAGE;
	localparam int DIV_STEPS_PER_STAGE = 3;
	localparam int DIV_STAGES          = (Q_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
	localparam int LATENCY             = 5 + SQ_STAGES + 1 + DIV_STAGES + 1;

	localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEWER_X    = 3'd0,
		REG_VIEWER_Y    = 3'd1,
		REG_COS_HEADING = 3'd2,
		REG_SIN_HEADING = 3'd3,
		REG_VIEW_RADIUS = 3'd4,
		REG_HEADING_UP  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [MARK_W-1:0] marker_x;
		logic signed [MARK_W-1:0] marker_y;
		logic                     in_view;
	} marker_t;

	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [Q_W-1:0]    q;
	} div_st_t;

	// per-item data that rides along the square root and divider stages
	typedef struct packed {
		logic [ABS_W-1:0] ax;
		logic [ABS_W-1:0] ay;
		logic             sx;
		logic             sy;
		logic             in_circle;
	} side_t;

	// one digit of the restoring square root
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t st);
		sqrt_st_t nx;
		logic [REM_W-1:0] rsh;
		logic [REM_W-1:0] trial;
		rsh   = {st.rem[REM_W-3:0], st.rad[SQ_W-1 -: 2]};
		trial = REM_W'({st.root, 2'b01});
		nx.rad = {st.rad[SQ_W-3:0], 2'b00};
		if (rsh >= trial) begin
			nx.rem  = rsh - trial;
			nx.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			nx.rem  = rsh;
			nx.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return nx;
	endfunction

	// one quotient bit; remainder stays below twice the divisor
	function automatic div_st_t div_step(input div_st_t st, input logic [ROOT_W-1:0] dv);
		div_st_t nx;
		logic [DREM_W-1:0] t;
		logic b;
		t = st.rem;
		b = (t >= DREM_W'(dv));
		if (b) begin
			t = t - DREM_W'(dv);
		end
		nx.rem = {t[DREM_W-2:0], 1'b0};
		nx.q   = {st.q[Q_W-2:0], b};
		return nx;
	endfunction

endpackage

[rtl/rotate_scale_radial_clamp_2d_top.sv]
// channel  | ports                     | handshake
// point    | start, busy, point        | taken when start && !busy
// marker   | done, marker              | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_index, cfg_data | write when cfg_we
//
// Fully pipelined: one point per cycle, busy is never raised.
// The pipeline depth is set by the 27-digit square root
// (3 digits a stage) and the 15-bit dividers (3 bits a stage).
// arst_n clears the valid bits and sets the config registers to their reset values; data registers are not reset.
// The receiver cannot stall, so no stage ever holds.
module rotate_scale_radial_clamp_2d_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  rsrc2d_pkg::point_t                    point,
	input  logic                                  cfg_we,
	input  logic [rsrc2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsrc2d_pkg::CFG_W-1:0]          cfg_data,
	output logic                                  done,
	output rsrc2d_pkg::marker_t                   marker
);
	import rsrc2d_pkg::*;

	logic signed [COORD_W-1:0] viewer_x_q, viewer_y_q;
	logic signed [TRIG_W-1:0]  cos_q, sin_q;
	logic [RADIUS_W-1:0]       radius_q;
	logic                      hup_q;
	logic [RADIUS_W-1:0]       r_eff;
	logic [RSQ_W-1:0]          rsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= '0;
			viewer_y_q <= '0;
			cos_q      <= TRIG_W'(16384);
			sin_q      <= '0;
			radius_q   <= RADIUS_W'(1);
			hup_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIEWER_X:    viewer_x_q <= cfg_data[COORD_W-1:0];
				REG_VIEWER_Y:    viewer_y_q <= cfg_data[COORD_W-1:0];
				REG_COS_HEADING: cos_q      <= cfg_data[TRIG_W-1:0];
				REG_SIN_HEADING: sin_q      <= cfg_data[TRIG_W-1:0];
				REG_VIEW_RADIUS: radius_q   <= cfg_data[RADIUS_W-1:0];
				REG_HEADING_UP:  hup_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign r_eff = (radius_q == '0) ? RADIUS_W'(1) : radius_q;

	always_ff @(posedge clk) begin
		rsq_q <= r_eff * r_eff;
	end

	assign busy = 1'b0;

	// s1: offsets
	logic                     v_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	// s2: rotation products
	logic                     v_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic signed [PROD_W-1:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	// s3: local frame
	logic                     v_s3;
	logic signed [L_W-1:0]    lx_s3, ly_s3;
	// s4: magnitudes and squares
	logic                     v_s4;
	logic [ABS_W-1:0]         ax_s4, ay_s4;
	logic                     sx_s4, sy_s4;
	logic [SQ_W-1:0]          sqx_s4, sqy_s4;
	// s5: distance squared
	logic                     v_s5;
	logic [SQ_W:0]            d2_sum;

	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic signed [L_W-1:0]    ax_full, ay_full;

	assign sum_x   = SUM_W'(pxc_s2) + SUM_W'(pys_s2);
	assign sum_y   = SUM_W'(pyc_s2) - SUM_W'(pxs_s2);
	assign ax_full = lx_s3[L_W-1] ? -lx_s3 : lx_s3;
	assign ay_full = ly_s3[L_W-1] ? -ly_s3 : ly_s3;
	assign d2_sum  = (SQ_W+1)'(sqx_s4) + (SQ_W+1)'(sqy_s4);

	logic     sv_s [SQ_STAGES+1];
	sqrt_st_t sq_s [SQ_STAGES+1];
	side_t    sd_s [SQ_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= DIFF_W'(point.point_x) - DIFF_W'(viewer_x_q);
		dy_s1  <= DIFF_W'(point.point_y) - DIFF_W'(viewer_y_q);
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		pxc_s2 <= dx_s1 * cos_q;
		pys_s2 <= dy_s1 * sin_q;
		pyc_s2 <= dy_s1 * cos_q;
		pxs_s2 <= dx_s1 * sin_q;
		// floor shift is the top bits of the sum
		lx_s3  <= hup_q ? sum_x[SUM_W-1:FRAC] : L_W'(dx_s2);
		ly_s3  <= hup_q ? sum_y[SUM_W-1:FRAC] : L_W'(dy_s2);
		ax_s4  <= ax_full[ABS_W-1:0];
		ay_s4  <= ay_full[ABS_W-1:0];
		sx_s4  <= lx_s3[L_W-1];
		sy_s4  <= ly_s3[L_W-1];
		sqx_s4 <= ax_full[ABS_W-1:0] * ax_full[ABS_W-1:0];
		sqy_s4 <= ay_full[ABS_W-1:0] * ay_full[ABS_W-1:0];
		sq_s[0].rad    <= d2_sum[SQ_W-1:0];
		sq_s[0].rem    <= '0;
		sq_s[0].root   <= '0;
		sd_s[0].ax     <= ax_s4;
		sd_s[0].ay     <= ay_s4;
		sd_s[0].sx     <= sx_s4;
		sd_s[0].sy     <= sy_s4;
		sd_s[0].in_circle <= d2_sum <= (SQ_W+1)'(rsq_q);
	end

	assign sv_s[0] = v_s5;

	for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sqrt
		sqrt_st_t nx;
		always_comb begin
			nx = sq_s[k-1];
			for (int j = 0; j < SQ_STEPS_PER_STAGE; j++) begin
				if ((k-1) * SQ_STEPS_PER_STAGE + j < ROOT_W) begin
					nx = sqrt_step(nx);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k] <= 1'b0;
			end else begin
				sv_s[k] <= sv_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			sq_s[k] <= nx;
			sd_s[k] <= sd_s[k-1];
		end
	end

	// divisor select and saturation flags
	logic              v_sel_s;
	logic [ROOT_W-1:0] dv_sel_s;
	logic              ovx_sel_s, ovy_sel_s;
	side_t             sd_sel_s;
	logic [ROOT_W-1:0] dv_pick;

	assign dv_pick = sd_s[SQ_STAGES].in_circle ? ROOT_W'(r_eff) : sq_s[SQ_STAGES].root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sel_s <= 1'b0;
		end else begin
			v_sel_s <= sv_s[SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		dv_sel_s  <= dv_pick;
		// quotient reaches 2^(FRAC+1) exactly when l >= 2*div
		ovx_sel_s <= DREM_W'(sd_s[SQ_STAGES].ax) >= {dv_pick, 1'b0};
		ovy_sel_s <= DREM_W'(sd_s[SQ_STAGES].ay) >= {dv_pick, 1'b0};
		sd_sel_s  <= sd_s[SQ_STAGES];
	end

	logic              dvv_s [DIV_STAGES+1];
	div_st_t           dx_st_s [DIV_STAGES+1];
	div_st_t           dy_st_s [DIV_STAGES+1];
	logic [ROOT_W-1:0] dv_s [DIV_STAGES+1];
	logic              ovx_s [DIV_STAGES+1];
	logic              ovy_s [DIV_STAGES+1];
	side_t             dsd_s [DIV_STAGES+1];

	assign dvv_s[0]       = v_sel_s;
	assign dx_st_s[0].rem = DREM_W'(sd_sel_s.ax);
	assign dx_st_s[0].q   = '0;
	assign dy_st_s[0].rem = DREM_W'(sd_sel_s.ay);
	assign dy_st_s[0].q   = '0;
	assign dv_s[0]        = dv_sel_s;
	assign ovx_s[0]       = ovx_sel_s;
	assign ovy_s[0]       = ovy_sel_s;
	assign dsd_s[0]       = sd_sel_s;

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		div_st_t nxx, nxy;
		always_comb begin
			nxx = dx_st_s[k-1];
			nxy = dy_st_s[k-1];
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				if ((k-1) * DIV_STEPS_PER_STAGE + j < Q_W) begin
					nxx = div_step(nxx, dv_s[k-1]);
					nxy = div_step(nxy, dv_s[k-1]);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k] <= 1'b0;
			end else begin
				dvv_s[k] <= dvv_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			dx_st_s[k] <= nxx;
			dy_st_s[k] <= nxy;
			dv_s[k]    <= dv_s[k-1];
			ovx_s[k]   <= ovx_s[k-1];
			ovy_s[k]   <= ovy_s[k-1];
			dsd_s[k]   <= dsd_s[k-1];
		end
	end

	logic [Q_W-1:0]    qx, qy;
	logic [MARK_W-1:0] mx, my;

	always_comb begin
		qx = (ovx_s[DIV_STAGES] || dx_st_s[DIV_STAGES].q > ONE) ? ONE : dx_st_s[DIV_STAGES].q;
		qy = (ovy_s[DIV_STAGES] || dy_st_s[DIV_STAGES].q > ONE) ? ONE : dy_st_s[DIV_STAGES].q;
		mx = dsd_s[DIV_STAGES].sx ? -MARK_W'(qx) : MARK_W'(qx);
		my = dsd_s[DIV_STAGES].sy ? -MARK_W'(qy) : MARK_W'(qy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvv_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		marker.marker_x <= mx;
		marker.marker_y <= my;
		marker.in_view  <= dsd_s[DIV_STAGES].in_circle;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("item did not come out after the pipeline latency");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(marker.marker_x) <= 16384 && $signed(marker.marker_x) >= -16384
			&& $signed(marker.marker_y) <= 16384 && $signed(marker.marker_y) >= -16384))
		else $error("marker outside the saturation range");

	a_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_sel_s |-> dv_sel_s != '0)
		else $error("zero divisor reached the dividers");

endmodule
